// ===== rtl/lsra_pkg.sv =====
// Shared types and constants of the linear scan register allocator.
// No dependencies; every other file imports this package.
package lsra_pkg;

  localparam int unsigned MAX_TEMPS_DEF     = 4096;
  localparam int unsigned MAX_REGS_DEF      = 32;
  localparam int unsigned MAX_POSITIONS_DEF = 65536;

  localparam int unsigned TEMP_IN_W  = 13;
  localparam int unsigned QUERY_W    = 12;
  localparam int unsigned REG_OUT_W  = 6;
  localparam int unsigned SLOT_W     = 13;
  localparam int unsigned RCNT_W     = 6;
  localparam int unsigned TLIM_W     = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [RCNT_W-1:0] REG_COUNT_RST  = RCNT_W'(16);
  localparam logic [TLIM_W-1:0] TEMP_LIMIT_RST = TLIM_W'(4096);

  localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT = 1'b1;

  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_CLR_INIT, ST_CLR, ST_IDLE, ST_Q_RD, ST_Q_OUT, ST_T_RD, ST_T_WR, ST_POS,
    ST_SAT_RD, ST_SAT_CK, ST_ZERO, ST_LOOP, ST_ORD_RD, ST_IV_RD, ST_IV_LAT,
    ST_EXP, ST_PICK, ST_VIC_INIT, ST_VIC, ST_SPILL, ST_SWAP, ST_NEXT, ST_FIN
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_CLR_INIT, OP_CLR_STEP, OP_T_RD, OP_T_WR, OP_POS_INC,
    OP_CNT_ZERO, OP_SAT_RD, OP_SAT_CK, OP_ORD_RD, OP_IV_RD, OP_IV_LAT, OP_EXP,
    OP_PICK, OP_VIC_INIT, OP_VIC, OP_SPILL, OP_SWAP, OP_NEXT, OP_Q_RD, OP_Q_OUT,
    OP_FIN
  } op_e;

  typedef struct packed {
    logic clr_last;
    logic k_last;
    logic rec_last;
    logic sat_seen;
    logic i_done;
    logic scan_done;
    logic has_free;
    logic do_swap;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/lsra_ctrl.sv =====
// Sequencer of the allocator: one state machine that issues one datapath
// operation per cycle. Depends on lsra_pkg.
module lsra_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  output logic              in_ready_o,
  input  lsra_pkg::status_t st_i,
  output lsra_pkg::op_e     op_o
);
  import lsra_pkg::*;

  state_e state_q, state_d;
  logic   rec_pend_q, rec_pend_d;
  logic   done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR_INIT;
      rec_pend_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      rec_pend_q <= rec_pend_d;
      done_q     <= done_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    rec_pend_d = rec_pend_q;
    done_d     = done_q;
    case (state_q)
      ST_CLR_INIT: state_d = ST_CLR;
      ST_CLR: begin
        if (st_i.clr_last) begin
          state_d    = rec_pend_q ? ST_T_RD : ST_IDLE;
          rec_pend_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_mode_i == MODE_QUERY) begin
            state_d = ST_Q_RD;
          end else if (done_q) begin
            state_d    = ST_CLR_INIT;
            rec_pend_d = 1'b1;
            done_d     = 1'b0;
          end else begin
            state_d = ST_T_RD;
          end
        end
      end
      ST_Q_RD:  state_d = ST_Q_OUT;
      ST_Q_OUT: if (st_i.out_free) state_d = ST_IDLE;
      ST_T_RD:  state_d = ST_T_WR;
      ST_T_WR:  state_d = st_i.k_last ? ST_POS : ST_T_RD;
      ST_POS: begin
        if (!st_i.rec_last) state_d = ST_IDLE;
        else if (st_i.sat_seen) state_d = ST_SAT_RD;
        else state_d = ST_LOOP;
      end
      ST_SAT_RD:   state_d = ST_SAT_CK;
      ST_SAT_CK:   state_d = st_i.clr_last ? ST_ZERO : ST_SAT_RD;
      ST_ZERO:     state_d = ST_LOOP;
      ST_LOOP:     state_d = st_i.i_done ? ST_FIN : ST_ORD_RD;
      ST_ORD_RD:   state_d = ST_IV_RD;
      ST_IV_RD:    state_d = ST_IV_LAT;
      ST_IV_LAT:   state_d = ST_EXP;
      ST_EXP:      if (st_i.scan_done) state_d = ST_PICK;
      ST_PICK:     state_d = st_i.has_free ? ST_NEXT : ST_VIC_INIT;
      ST_VIC_INIT: state_d = ST_VIC;
      ST_VIC:      if (st_i.scan_done) state_d = ST_SPILL;
      ST_SPILL:    state_d = st_i.do_swap ? ST_SWAP : ST_NEXT;
      ST_SWAP:     state_d = ST_NEXT;
      ST_NEXT:     state_d = ST_LOOP;
      ST_FIN: begin
        if (st_i.out_free) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default:     state_d = ST_CLR_INIT;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    op_o       = OP_NONE;
    case (state_q)
      ST_CLR_INIT: op_o = OP_CLR_INIT;
      ST_CLR:      op_o = OP_CLR_STEP;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_CAPTURE;
      end
      ST_Q_RD:     op_o = OP_Q_RD;
      ST_Q_OUT:    if (st_i.out_free) op_o = OP_Q_OUT;
      ST_T_RD:     op_o = OP_T_RD;
      ST_T_WR:     op_o = OP_T_WR;
      ST_POS:      op_o = OP_POS_INC;
      ST_SAT_RD:   op_o = OP_SAT_RD;
      ST_SAT_CK:   op_o = OP_SAT_CK;
      ST_ZERO:     op_o = OP_CNT_ZERO;
      ST_ORD_RD:   op_o = OP_ORD_RD;
      ST_IV_RD:    op_o = OP_IV_RD;
      ST_IV_LAT:   op_o = OP_IV_LAT;
      ST_EXP:      op_o = OP_EXP;
      ST_PICK:     op_o = OP_PICK;
      ST_VIC_INIT: op_o = OP_VIC_INIT;
      ST_VIC:      op_o = OP_VIC;
      ST_SPILL:    op_o = OP_SPILL;
      ST_SWAP:     op_o = OP_SWAP;
      ST_NEXT:     op_o = OP_NEXT;
      ST_FIN:      if (st_i.out_free) op_o = OP_FIN;
      default:     op_o = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/lsra_dp.sv =====
// Datapath of the allocator: interval, assignment and order memories, the
// active list, counters, configuration and the result register. Uses lsra_pkg.
module lsra_dp #(
  parameter int unsigned MAX_TEMPS     = lsra_pkg::MAX_TEMPS_DEF,
  parameter int unsigned MAX_REGS      = lsra_pkg::MAX_REGS_DEF,
  parameter int unsigned MAX_POSITIONS = lsra_pkg::MAX_POSITIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lsra_pkg::op_e                       op_i,
  output lsra_pkg::status_t                   st_o,
  input  logic                                cfg_we_i,
  input  logic [lsra_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lsra_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [lsra_pkg::TEMP_IN_W-1:0]      dest_i,
  input  logic [lsra_pkg::TEMP_IN_W-1:0]      src_a_i,
  input  logic [lsra_pkg::TEMP_IN_W-1:0]      src_b_i,
  input  logic                                last_i,
  input  logic [lsra_pkg::QUERY_W-1:0]        query_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                out_kind_o,
  output logic [lsra_pkg::REG_OUT_W-1:0]      out_reg_o,
  output logic [lsra_pkg::SLOT_W-1:0]         out_slot_o,
  output logic [lsra_pkg::SLOT_W-1:0]         out_total_o
);
  import lsra_pkg::*;

  localparam int unsigned TW   = $clog2(MAX_TEMPS);
  localparam int unsigned NW   = TW + 1;
  localparam int unsigned RW   = $clog2(MAX_REGS);
  localparam int unsigned CW   = $clog2(MAX_REGS + 1);
  localparam int unsigned PW   = $clog2(MAX_POSITIONS);
  localparam int unsigned IVW  = 2 * PW + 1;
  localparam int unsigned ASW  = 1 + RW + SLOT_W;
  localparam logic [PW-1:0]     POS_SAT   = PW'(MAX_POSITIONS - 1);
  localparam logic [SLOT_W-1:0] SLOT_NONE = '1;
  localparam logic [ASW-1:0]    ASG_NONE  = {1'b0, {RW{1'b0}}, SLOT_NONE};

  // configuration
  logic [RCNT_W-1:0] rcnt_q;
  logic [TLIM_W-1:0] tlim_q;
  logic [31:0]       lim, rc;

  // captured item
  logic [TW-1:0]      t_q [3];
  logic [2:0]         tv_q;
  logic               last_q;
  logic [QUERY_W-1:0] q_q;
  logic               q_ok_q;
  logic [1:0]         k_q;

  // counters and scan state
  logic [NW-1:0]     cnt_q, n_q;
  logic [PW-1:0]     pos_q;
  logic [SLOT_W-1:0] spill_q;
  logic              sat_seen_q;
  logic [TW-1:0]     cur_q, vtemp_q;
  logic [PW-1:0]     start_q, end_q, max_q;
  logic [RW-1:0]     vreg_q;
  logic [CW-1:0]     vpos_q, j_q, act_cnt_q;

  // active list and register occupancy
  logic [TW-1:0]       act_temp_q [MAX_REGS];
  logic [PW-1:0]       act_end_q  [MAX_REGS];
  logic [RW-1:0]       act_reg_q  [MAX_REGS];
  logic [MAX_REGS-1:0] busy_q;

  // memories
  logic [IVW-1:0] iv_mem  [MAX_TEMPS];
  logic [ASW-1:0] asg_mem [MAX_TEMPS];
  logic [TW-1:0]  ord_mem [MAX_TEMPS];
  logic           iv_re, iv_we, asg_re, asg_we, ord_re, ord_we;
  logic [TW-1:0]  iv_ra, iv_wa, asg_ra, asg_wa, ord_ra, ord_wa, ord_wd;
  logic [IVW-1:0] iv_wd, iv_rd_q;
  logic [ASW-1:0] asg_wd, asg_rd_q;
  logic [TW-1:0]  ord_rd_q;

  logic          rd_used;
  logic [PW-1:0] rd_first, rd_last;
  logic          t_new, t_append;
  logic          has_free, do_swap;
  logic [RW-1:0] free_idx;
  logic [TW:0]   key [3];
  logic [TW:0]   ks  [3];
  logic [TW:0]   tmp;

  assign rd_used  = iv_rd_q[IVW-1];
  assign rd_first = iv_rd_q[2*PW-1:PW];
  assign rd_last  = iv_rd_q[PW-1:0];
  assign t_new    = tv_q[k_q] && !rd_used;
  assign t_append = t_new && (pos_q != POS_SAT);
  assign do_swap  = (act_cnt_q != '0) && (max_q > end_q);

  always_comb begin
    lim = (32'(tlim_q) > 32'(MAX_TEMPS)) ? 32'(MAX_TEMPS) : 32'(tlim_q);
    rc  = (32'(rcnt_q) > 32'(MAX_REGS)) ? 32'(MAX_REGS) : 32'(rcnt_q);
  end

  // Order the three temporaries ascending; ignored ones sort to the end.
  always_comb begin
    key[0] = {dest_i[12]  || (32'(dest_i[11:0])  >= lim), TW'(dest_i[11:0])};
    key[1] = {src_a_i[12] || (32'(src_a_i[11:0]) >= lim), TW'(src_a_i[11:0])};
    key[2] = {src_b_i[12] || (32'(src_b_i[11:0]) >= lim), TW'(src_b_i[11:0])};
    ks  = key;
    tmp = '0;
    if (ks[0] > ks[1]) begin tmp = ks[0]; ks[0] = ks[1]; ks[1] = tmp; end
    if (ks[1] > ks[2]) begin tmp = ks[1]; ks[1] = ks[2]; ks[2] = tmp; end
    if (ks[0] > ks[1]) begin tmp = ks[0]; ks[0] = ks[1]; ks[1] = tmp; end
  end

  // Lowest free register below the configured count.
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int r = 0; r < MAX_REGS; r++) begin
      if (!has_free && !busy_q[r] && (32'(r) < rc)) begin
        has_free = 1'b1;
        free_idx = RW'(r);
      end
    end
  end

  always_comb begin
    iv_re  = 1'b0; iv_ra  = '0; iv_we  = 1'b0; iv_wa  = '0; iv_wd  = '0;
    asg_re = 1'b0; asg_ra = '0; asg_we = 1'b0; asg_wa = '0; asg_wd = ASG_NONE;
    ord_re = 1'b0; ord_ra = '0; ord_we = 1'b0; ord_wa = n_q[TW-1:0]; ord_wd = '0;
    case (op_i)
      OP_CLR_STEP: begin
        iv_we  = 1'b1;
        iv_wa  = cnt_q[TW-1:0];
        asg_we = 1'b1;
        asg_wa = cnt_q[TW-1:0];
      end
      OP_T_RD: begin
        iv_re = 1'b1;
        iv_ra = t_q[k_q];
      end
      OP_T_WR: begin
        iv_we  = tv_q[k_q];
        iv_wa  = t_q[k_q];
        iv_wd  = {1'b1, rd_used ? rd_first : pos_q, pos_q};
        ord_we = t_append;
        ord_wd = t_q[k_q];
      end
      OP_SAT_RD: begin
        iv_re = 1'b1;
        iv_ra = cnt_q[TW-1:0];
      end
      OP_SAT_CK: begin
        ord_we = rd_used && (rd_first == POS_SAT);
        ord_wd = cnt_q[TW-1:0];
      end
      OP_ORD_RD: begin
        ord_re = 1'b1;
        ord_ra = cnt_q[TW-1:0];
      end
      OP_IV_RD: begin
        iv_re = 1'b1;
        iv_ra = ord_rd_q;
      end
      OP_PICK: begin
        asg_we = has_free;
        asg_wa = cur_q;
        asg_wd = {1'b1, free_idx, SLOT_NONE};
      end
      OP_SPILL: begin
        asg_we = 1'b1;
        asg_wa = do_swap ? vtemp_q : cur_q;
        asg_wd = {1'b0, {RW{1'b0}}, spill_q};
      end
      OP_SWAP: begin
        asg_we = 1'b1;
        asg_wa = cur_q;
        asg_wd = {1'b1, vreg_q, SLOT_NONE};
      end
      OP_Q_RD: begin
        asg_re = 1'b1;
        asg_ra = TW'(q_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (iv_we) iv_mem[iv_wa] <= iv_wd;
    if (iv_re) iv_rd_q <= iv_mem[iv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (asg_we) asg_mem[asg_wa] <= asg_wd;
    if (asg_re) asg_rd_q <= asg_mem[asg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (ord_re) ord_rd_q <= ord_mem[ord_ra];
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_CAPTURE: begin
        for (int i = 0; i < 3; i++) begin
          t_q[i]  <= ks[i][TW-1:0];
          tv_q[i] <= !ks[i][TW];
        end
        last_q <= last_i;
        q_q    <= query_i;
        q_ok_q <= 32'(query_i) < 32'(MAX_TEMPS);
      end
      OP_IV_RD: cur_q <= ord_rd_q;
      OP_IV_LAT: begin
        start_q <= rd_first;
        end_q   <= rd_last;
      end
      OP_EXP: begin
        if ((j_q < act_cnt_q) && (act_end_q[j_q[RW-1:0]] < start_q)) begin
          for (int e = 0; e < MAX_REGS - 1; e++) begin
            if (CW'(e) >= j_q) begin
              act_temp_q[e] <= act_temp_q[e+1];
              act_end_q[e]  <= act_end_q[e+1];
              act_reg_q[e]  <= act_reg_q[e+1];
            end
          end
        end
      end
      OP_PICK: begin
        if (has_free && (act_cnt_q < CW'(MAX_REGS))) begin
          act_temp_q[act_cnt_q[RW-1:0]] <= cur_q;
          act_end_q[act_cnt_q[RW-1:0]]  <= end_q;
          act_reg_q[act_cnt_q[RW-1:0]]  <= free_idx;
        end
      end
      OP_VIC_INIT: begin
        max_q   <= act_end_q[0];
        vpos_q  <= '0;
        vtemp_q <= act_temp_q[0];
        vreg_q  <= act_reg_q[0];
      end
      OP_VIC: begin
        if ((j_q < act_cnt_q) && (act_end_q[j_q[RW-1:0]] > max_q)) begin
          max_q   <= act_end_q[j_q[RW-1:0]];
          vpos_q  <= j_q;
          vtemp_q <= act_temp_q[j_q[RW-1:0]];
          vreg_q  <= act_reg_q[j_q[RW-1:0]];
        end
      end
      OP_SWAP: begin
        act_temp_q[vpos_q[RW-1:0]] <= cur_q;
        act_end_q[vpos_q[RW-1:0]]  <= end_q;
      end
      OP_Q_OUT: begin
        out_kind_o  <= KIND_QUERY;
        out_reg_o   <= (q_ok_q && asg_rd_q[ASW-1]) ?
                       REG_OUT_W'(asg_rd_q[ASW-2:SLOT_W]) : {REG_OUT_W{1'b1}};
        out_slot_o  <= q_ok_q ? asg_rd_q[SLOT_W-1:0] : SLOT_NONE;
        out_total_o <= spill_q;
      end
      OP_FIN: begin
        out_kind_o  <= KIND_DONE;
        out_reg_o   <= {REG_OUT_W{1'b1}};
        out_slot_o  <= SLOT_NONE;
        out_total_o <= spill_q;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q      <= REG_COUNT_RST;
      tlim_q      <= TEMP_LIMIT_RST;
      k_q         <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      pos_q       <= '0;
      spill_q     <= '0;
      sat_seen_q  <= 1'b0;
      j_q         <= '0;
      act_cnt_q   <= '0;
      busy_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_REG_COUNT)) rcnt_q <= cfg_data_i[RCNT_W-1:0];
      if (cfg_we_i && (cfg_idx_i == CFG_TEMP_LIMIT)) tlim_q <= cfg_data_i[TLIM_W-1:0];
      if ((op_i == OP_Q_OUT) || (op_i == OP_FIN)) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (op_i)
        OP_CAPTURE: k_q <= '0;
        OP_CLR_INIT: begin
          cnt_q      <= '0;
          n_q        <= '0;
          pos_q      <= '0;
          spill_q    <= '0;
          sat_seen_q <= 1'b0;
          act_cnt_q  <= '0;
          busy_q     <= '0;
        end
        OP_CLR_STEP, OP_NEXT: cnt_q <= cnt_q + 1'b1;
        OP_T_WR: begin
          k_q <= k_q + 1'b1;
          if (t_append) n_q <= n_q + 1'b1;
          if (t_new && (pos_q == POS_SAT)) sat_seen_q <= 1'b1;
        end
        OP_POS_INC: begin
          if (pos_q != POS_SAT) pos_q <= pos_q + 1'b1;
          cnt_q <= '0;
        end
        OP_CNT_ZERO: cnt_q <= '0;
        OP_SAT_CK: begin
          if (rd_used && (rd_first == POS_SAT)) n_q <= n_q + 1'b1;
          cnt_q <= cnt_q + 1'b1;
        end
        OP_IV_LAT: j_q <= '0;
        OP_EXP: begin
          if (j_q < act_cnt_q) begin
            if (act_end_q[j_q[RW-1:0]] < start_q) begin
              busy_q[act_reg_q[j_q[RW-1:0]]] <= 1'b0;
              act_cnt_q <= act_cnt_q - 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        OP_PICK: begin
          if (has_free) begin
            busy_q[free_idx] <= 1'b1;
            if (act_cnt_q < CW'(MAX_REGS)) act_cnt_q <= act_cnt_q + 1'b1;
          end
        end
        OP_VIC_INIT: j_q <= CW'(1);
        OP_VIC: if (j_q < act_cnt_q) j_q <= j_q + 1'b1;
        OP_SPILL: spill_q <= spill_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_o.clr_last  = (cnt_q == NW'(MAX_TEMPS - 1));
    st_o.k_last    = (k_q == 2'd2);
    st_o.rec_last  = last_q;
    st_o.sat_seen  = sat_seen_q;
    st_o.i_done    = (cnt_q >= n_q);
    st_o.scan_done = (j_q >= act_cnt_q);
    st_o.has_free  = has_free;
    st_o.do_swap   = do_swap;
    st_o.out_free  = !out_valid_o || out_ready_i;
  end

`ifndef SYNTHESIS
  // Every active interval holds exactly one busy register.
  a_busy_matches_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q) == int'(act_cnt_q))
    else $error("busy registers and active list disagree");

  // The ordered list never holds more intervals than there are temporaries.
  a_order_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_TEMPS))
    else $error("interval count exceeds table depth");

  // A victim swap always follows the spill decision that chose it.
  a_swap_after_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_SWAP) |-> ($past(op_i) == OP_SPILL))
    else $error("swap issued without a spill decision");
`endif

endmodule

// ===== rtl/linear_scan_register_allocator_unit.sv =====
// Top level of the linear scan register allocator: stream ports, sequencer
// and datapath. Depends on lsra_pkg, lsra_ctrl and lsra_dp.
//
//   channel  direction  handshake                     payload
//   s_axis   in         s_axis_tvalid/s_axis_tready   tuser mode, tlast last, tdata temps
//   m_axis   out        m_axis_tvalid/m_axis_tready   tuser kind, tdata reg/slot/total
//   cfg      in         cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
// An instruction record is accepted, then each of its three temporaries gets a read
// of the interval memory and, when it is used, a write, and then the position
// advances. A query goes through the registered read of the assignment memory.
// After reset, and when the first record of a new program arrives, a clearing
// pass over MAX_TEMPS entries runs with s_axis_tready low. The final record then
// runs the allocation: per interval the order and interval memories are read,
// expired active entries are removed and, when no register is free, the active
// list is searched for a victim; if the position counter saturated, a scan of the
// interval memory first orders the late intervals.
// A result waits in the output register while the next transaction is taken.
module linear_scan_register_allocator_unit #(
  parameter int unsigned MAX_TEMPS     = lsra_pkg::MAX_TEMPS_DEF,
  parameter int unsigned MAX_REGS      = lsra_pkg::MAX_REGS_DEF,
  parameter int unsigned MAX_POSITIONS = lsra_pkg::MAX_POSITIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // dest_temp[12:0], src_a_temp[25:13], src_b_temp[38:26], query_temp[50:39]
  input  logic [lsra_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // mode
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // assigned_register[5:0], spill_slot[18:6], spills_total[31:19]
  output logic [lsra_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // kind
  output logic                                m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [lsra_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lsra_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import lsra_pkg::*;

  op_e                   op;
  status_t               st;
  logic [REG_OUT_W-1:0]  out_reg;
  logic [SLOT_W-1:0]     out_slot, out_total;

  // The sequencer only looks at the mode bit; all payload goes to the datapath.
  lsra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .op_o       (op)
  );

  lsra_dp #(
    .MAX_TEMPS     (MAX_TEMPS),
    .MAX_REGS      (MAX_REGS),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .st_o        (st),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .dest_i      (s_axis_tdata[12:0]),
    .src_a_i     (s_axis_tdata[25:13]),
    .src_b_i     (s_axis_tdata[38:26]),
    .last_i      (s_axis_tlast),
    .query_i     (s_axis_tdata[50:39]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_reg_o   (out_reg),
    .out_slot_o  (out_slot),
    .out_total_o (out_total)
  );

  // Result fields are packed from the lowest bit up.
  assign m_axis_tdata = {out_total, out_slot, out_reg};

endmodule
